>>> hw/rtl/tlse_pkg.sv
// tlse_pkg: constants, types and the correction rom builder for the
// two-operand log-sum-exp block; depends on nothing else
package tlse_pkg;

	localparam int TABLE_DEPTH  = 16384;
	localparam int CUTOFF_MILLI = 15700;

	// threshold count of the rom builder, bounds the correction value
	localparam int TH_COUNT = 700;

	localparam int CORR_W     = $clog2(TH_COUNT);
	localparam int IDX_W      = $clog2(TABLE_DEPTH);
	localparam int CORR_LIMIT = (CUTOFF_MILLI < TABLE_DEPTH) ? CUTOFF_MILLI : TABLE_DEPTH;

	localparam longint unsigned Q_ONE = 64'd1 << 62;
	localparam longint unsigned M32   = 64'h0000_0000_FFFF_FFFF;

	typedef logic [CORR_W-1:0] corr_rom_t [TABLE_DEPTH];

	// q2.62 product, truncated
	function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
		longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
		al  = a & M32;
		ah  = a >> 32;
		bl  = b & M32;
		bh  = b >> 32;
		ll  = al * bl;
		lh  = al * bh;
		hl  = ah * bl;
		hh  = ah * bh;
		mid = (ll >> 32) + (lh & M32) + (hl & M32);
		lo  = (mid << 32) | (ll & M32);
		hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
		return (hi << 2) | (lo >> 62);
	endfunction

	// exp(+-1/2000) in q2.62, series summed through the twelfth-power term
	function automatic longint unsigned exp_half_milli(bit neg);
		longint unsigned t, s;
		t = Q_ONE;
		s = Q_ONE;
		t = t / 64'd2000;  s = neg ? s - t : s + t;
		t = t / 64'd4000;  s = s + t;
		t = t / 64'd6000;  s = neg ? s - t : s + t;
		t = t / 64'd8000;  s = s + t;
		t = t / 64'd10000; s = neg ? s - t : s + t;
		t = t / 64'd12000; s = s + t;
		t = t / 64'd14000; s = neg ? s - t : s + t;
		t = t / 64'd16000; s = s + t;
		t = t / 64'd18000; s = neg ? s - t : s + t;
		t = t / 64'd20000; s = s + t;
		t = t / 64'd22000; s = neg ? s - t : s + t;
		t = t / 64'd24000; s = s + t;
		return s;
	endfunction

	// entry i = round(1000*ln(1+exp(-(i+0.5)/1000))), found by walking
	// thresholds th[v] = exp((v-0.5)/1000) against 1+y
	function automatic corr_rom_t build_corr_rom();
		corr_rom_t       rom;
		longint unsigned th [TH_COUNT];
		longint unsigned qm, qp, qp2, stp, y, onep;
		int              v;
		qm  = exp_half_milli(1'b1);
		qp  = exp_half_milli(1'b0);
		qp2 = qmul(qp, qp);
		stp = qmul(qm, qm);
		y   = qm;
		v   = 0;
		th[0] = 64'd0;
		th[1] = qp;
		for (int i = 2; i < TH_COUNT; i++) begin
			th[i] = qmul(th[i-1], qp2);
		end
		while (v + 1 < TH_COUNT && th[v+1] <= Q_ONE + y) begin
			v++;
		end
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			onep = Q_ONE + y;
			while (v > 0 && th[v] > onep) begin
				v--;
			end
			rom[i] = CORR_W'(v);
			y = qmul(y, stp);
		end
		return rom;
	endfunction

endpackage

>>> hw/rtl/table_log_sum_exp_two_operand.sv
// table_log_sum_exp_two_operand: max-star log-add of two milli-nat scores
// by correction rom lookup, or a plain maximum in max mode; depends on tlse_pkg
//
// pipeline: the start beat passes the input, rom and result registers before the done strobe
// throughput: one beat per cycle, busy is never raised (receiver cannot stall)
// reset: arst_n clears the valid pipeline and max_mode; the rom is constant,
// so no clearing pass is needed and a beat may start right after reset
module table_log_sum_exp_two_operand (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	// command side
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] operand_a,
	input  logic               a_neg_inf,
	input  logic signed [31:0] operand_b,
	input  logic               b_neg_inf,
	// result side
	output logic               done,
	output logic signed [31:0] sum_value,
	output logic               sum_neg_inf
);

	// correction rom, filled once at time zero and never written again
	tlse_pkg::corr_rom_t corr_rom;

	initial begin
		corr_rom = tlse_pkg::build_corr_rom();
	end

	// fully pipelined, never stalls
	assign busy = 1'b0;

	// max mode register (viterbi style plain maximum)
	logic max_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_mode_q <= 1'b0;
		end else if (cfg_we) begin
			max_mode_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: input register
	// ---------------------------------------------------------------
	logic               valid_s1;
	logic signed [31:0] a_s1, b_s1;
	logic               an_s1, bn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			a_s1  <= operand_a;
			an_s1 <= a_neg_inf;
			b_s1  <= operand_b;
			bn_s1 <= b_neg_inf;
		end
	end

	// larger operand and distance; the difference is formed once, its sign
	// picks the larger operand and the magnitude addresses the rom
	logic signed [32:0]         diff;
	logic                       a_gt;
	logic        [31:0]         mag;
	logic signed [31:0]         hi_sel;
	logic                       use_corr;
	logic        [tlse_pkg::IDX_W-1:0] rom_idx;

	always_comb begin
		diff = 33'(a_s1) - 33'(b_s1);
		a_gt = ~diff[32] & (diff != '0);
		mag  = a_gt ? diff[31:0] : 32'(-diff);
		// a flagged operand drops out and the other passes unchanged
		if (an_s1) begin
			hi_sel = b_s1;
		end else if (bn_s1) begin
			hi_sel = a_s1;
		end else begin
			hi_sel = a_gt ? a_s1 : b_s1;
		end
		// beyond the cutoff or the end of the table the correction is zero
		use_corr = ~max_mode_q & ~an_s1 & ~bn_s1 & (mag < 32'(tlse_pkg::CORR_LIMIT));
		rom_idx  = mag[tlse_pkg::IDX_W-1:0];
	end

	// ---------------------------------------------------------------
	// stage 2: rom read, registered
	// ---------------------------------------------------------------
	logic                              valid_s2;
	logic signed [31:0]                hi_s2;
	logic                              use_corr_s2;
	logic                              both_inf_s2;
	logic        [tlse_pkg::CORR_W-1:0] corr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		hi_s2       <= hi_sel;
		use_corr_s2 <= use_corr;
		both_inf_s2 <= an_s1 & bn_s1;
		corr_s2     <= corr_rom[rom_idx];
	end

	// add the correction, saturate at the top of the range
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_next;

	always_comb begin
		sum_wide = 33'(hi_s2) + 33'($signed({1'b0, corr_s2}));
		if (both_inf_s2) begin
			sum_next = '0;
		end else if (!use_corr_s2) begin
			sum_next = hi_s2;
		end else if (sum_wide > 33'sd2147483647) begin
			sum_next = 32'sh7FFF_FFFF;
		end else begin
			sum_next = sum_wide[31:0];
		end
	end

	// ---------------------------------------------------------------
	// stage 3: result register, one strobe per beat
	// ---------------------------------------------------------------
	logic               valid_s3;
	logic signed [31:0] sum_s3;
	logic               neg_inf_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3     <= sum_next;
		neg_inf_s3 <= both_inf_s2;
	end

	assign done        = valid_s3;
	assign sum_value   = sum_s3;
	assign sum_neg_inf = neg_inf_s3;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------

	// both operands minus infinity gives a zero value field
	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && sum_neg_inf |-> sum_value == '0)
		else $error("both-inf result with non-zero value");

	// without correction the larger operand passes unchanged
	a_pass_hi: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !both_inf_s2 && !use_corr_s2 |=> sum_value == $past(hi_s2))
		else $error("larger operand not passed through");

	// the correction never lowers the result
	a_corr_up: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && use_corr_s2 |=> sum_value >= $past(hi_s2))
		else $error("corrected sum below larger operand");

	// a both-inf beat in stage 1 reaches the output through the stage 2 and stage 3 registers
	a_inf_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && an_s1 && bn_s1 |=> ##1 done && sum_neg_inf)
		else $error("both-inf beat lost in pipeline");

endmodule
